### src/spq_pkg.sv
// Package for the sorted priority queue: default sizing, request and status
// codes, and the sequencer state type. No dependencies.
package spq_pkg;

	localparam int unsigned SPQ_DEPTH = 16;
	localparam int unsigned VALUE_W   = 32;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_FIND   = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_WRITE,
		S_FINISH
	} state_t;

endpackage

### src/sorted_priority_queue_top.sv
// Sorted priority queue: ascending list of signed values in a RAM, driven by a
// small sequencer with one shared compare and one RAM port pair.
// Depends on spq_pkg and spq_ram.
//
// Channel  Dir  Fields (lowest bit first)
// s_*      in   tuser: req_type[1:0]; tdata: value[31:0]
// m_*      out  tuser: status[1:0]; tdata: position[3:0], head_value[35:4],
//               is_empty[36], entry_count[41:37]
//
// An item passes through accept, a scan up to the first hit (registered RAM
// read), a shift of the moved entries, the insert write and the load of the
// output register; finds skip the shift, removes skip the insert write, and
// full inserts and unused codes go straight from accept to the output register.
// Reset empties the list at once. A waiting result holds the sequencer in its
// finish state, so no further result is loaded until that result transfers.
module sorted_priority_queue_top
	import spq_pkg::*;
#(
	parameter int unsigned DEPTH = SPQ_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // value[31:0]
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // position, head_value, is_empty, entry_count
	output logic [1:0]  m_tuser    // status[1:0]
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	state_t state_q, state_d;

	logic [CW-1:0]      count_q;
	req_t               op_q;
	logic [VALUE_W-1:0] val_q;
	status_t            st_q;
	logic [AW-1:0]      pos_q;
	logic [VALUE_W-1:0] head_q;

	logic [CW-1:0] scan_idx_q;
	logic          cmp_valid_s1;
	logic [AW-1:0] cmp_idx_s1;

	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] remain_q;
	logic          wr_pend_s1;
	logic [AW-1:0] wr_addr_s1;

	logic          out_valid_q;
	status_t       out_status_q;
	logic [3:0]    out_pos_q;
	logic [31:0]   out_head_q;
	logic          out_empty_q;
	logic [4:0]    out_count_q;

	logic               ram_wr_en;
	logic [AW-1:0]      ram_wr_addr;
	logic [VALUE_W-1:0] ram_wr_data;
	logic [AW-1:0]      ram_rd_addr;
	logic [VALUE_W-1:0] ram_rd_data;

	logic          in_xfer;
	logic          scan_issue;
	logic          hit;
	logic          cmp_hit;
	logic          scan_miss;
	logic          shift_issue;
	logic          shift_done;
	logic          out_load;
	logic [CW-1:0] cnt_m1;
	logic [CW+4:0] cnt_wide;
	logic [AW+3:0] pos_wide;

	assign s_tready = (state_q == S_IDLE);
	assign in_xfer  = s_tvalid && s_tready;

	assign scan_issue  = (state_q == S_SCAN) && (scan_idx_q < count_q);
	assign hit         = (op_q == REQ_INSERT) ? ($signed(ram_rd_data) >= $signed(val_q))
	                                          : (ram_rd_data == val_q);
	assign cmp_hit     = (state_q == S_SCAN) && cmp_valid_s1 && hit;
	assign scan_miss   = (state_q == S_SCAN) && !cmp_valid_s1 && (scan_idx_q == count_q);
	assign shift_issue = (state_q == S_SHIFT) && (remain_q != '0);
	assign shift_done  = (state_q == S_SHIFT) && (remain_q == '0) && !wr_pend_s1;
	assign out_load    = (state_q == S_FINISH) && (!out_valid_q || m_tready);
	assign cnt_m1      = count_q - CW'(1);

	// The RAM is written by the shift pipeline or by the final insert write.
	assign ram_wr_en   = wr_pend_s1 || (state_q == S_WRITE);
	assign ram_wr_addr = (state_q == S_WRITE) ? pos_q : wr_addr_s1;
	assign ram_wr_data = (state_q == S_WRITE) ? val_q : ram_rd_data;
	assign ram_rd_addr = (state_q == S_SCAN) ? scan_idx_q[AW-1:0] : rd_ptr_q;

	spq_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					if (s_tuser == REQ_INSERT && count_q == CW'(DEPTH)) begin
						state_d = S_FINISH;
					end else if (s_tuser == REQ_INSERT || s_tuser == REQ_REMOVE
						|| s_tuser == REQ_FIND) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_SCAN: begin
				if (cmp_hit) begin
					state_d = (op_q == REQ_FIND) ? S_FINISH : S_SHIFT;
				end else if (scan_miss) begin
					state_d = (op_q == REQ_INSERT) ? S_SHIFT : S_FINISH;
				end
			end
			S_SHIFT: begin
				if (shift_done) begin
					state_d = (op_q == REQ_INSERT) ? S_WRITE : S_FINISH;
				end
			end
			S_WRITE: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers of the scan and shift pipelines and the entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			cmp_valid_s1 <= 1'b0;
			wr_pend_s1   <= 1'b0;
		end else begin
			cmp_valid_s1 <= scan_issue;
			wr_pend_s1   <= shift_issue;
			if (state_q == S_WRITE) begin
				count_q <= count_q + CW'(1);
			end else if (shift_done && op_q == REQ_REMOVE) begin
				count_q <= cnt_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q       <= req_t'(s_tuser);
			val_q      <= s_tdata[VALUE_W-1:0];
			scan_idx_q <= '0;
			pos_q      <= '0;
			if (s_tuser == REQ_INSERT && count_q == CW'(DEPTH)) begin
				st_q <= ST_FULL;
			end else begin
				st_q <= ST_NOT_FOUND;
			end
		end
		if (scan_issue) begin
			scan_idx_q <= scan_idx_q + CW'(1);
			cmp_idx_s1 <= scan_idx_q[AW-1:0];
		end
		if (cmp_hit) begin
			st_q  <= ST_DONE;
			pos_q <= cmp_idx_s1;
			if (op_q == REQ_INSERT) begin
				remain_q <= count_q - CW'(cmp_idx_s1);
				rd_ptr_q <= cnt_m1[AW-1:0];
			end else begin
				remain_q <= cnt_m1 - CW'(cmp_idx_s1);
				rd_ptr_q <= cmp_idx_s1 + AW'(1);
			end
		end else if (scan_miss && op_q == REQ_INSERT) begin
			// Nothing is greater or equal: the value goes at the tail.
			st_q     <= ST_DONE;
			pos_q    <= count_q[AW-1:0];
			remain_q <= '0;
		end
		if (shift_issue) begin
			remain_q <= remain_q - CW'(1);
			if (op_q == REQ_INSERT) begin
				rd_ptr_q   <= rd_ptr_q - AW'(1);
				wr_addr_s1 <= rd_ptr_q + AW'(1);
			end else begin
				rd_ptr_q   <= rd_ptr_q + AW'(1);
				wr_addr_s1 <= rd_ptr_q - AW'(1);
			end
		end
		// The head is a copy of entry zero, refreshed on every write there.
		if (ram_wr_en && ram_wr_addr == '0) begin
			head_q <= ram_wr_data;
		end
	end

	assign cnt_wide = (CW+5)'(count_q);
	assign pos_wide = (AW+4)'(pos_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= st_q;
			out_pos_q    <= (st_q == ST_DONE) ? pos_wide[3:0] : 4'd0;
			out_head_q   <= (count_q == '0) ? '0 : head_q;
			out_empty_q  <= (count_q == '0);
			out_count_q  <= cnt_wide[4:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {6'd0, out_count_q, out_empty_q, out_head_q, out_pos_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds the list depth");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr_en |-> (state_q == S_SHIFT || state_q == S_WRITE))
		else $error("RAM written outside the shift or insert write");

	a_cmp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmp_valid_s1 && state_q == S_SCAN) |-> (CW'(cmp_idx_s1) < count_q))
		else $error("scan compared an entry beyond the stored count");

	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == S_SCAN || state_q == S_FINISH))
		else $error("accepted request did not start a scan or finish");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_empty_q == (out_count_q == 5'd0 && count_q == '0)
			|| out_empty_q == (out_count_q == 5'd0)))
		else $error("empty flag disagrees with the reported count");

	a_full_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE) |-> (count_q < CW'(DEPTH)))
		else $error("insert write with a full list");

endmodule

### src/spq_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
// Standalone, no package dependencies.
module spq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

### verif/spq_checker.sv
// Checker for the sorted priority queue: watches both stream channels, keeps
// its own copy of the sorted list and compares every result with it.
// Depends on spq_pkg.
`timescale 1ns / 100ps

module spq_checker
	import spq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // value[31:0]
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,   // position, head_value, is_empty, entry_count
	input  logic [1:0]  m_tuser,   // status[1:0]
	output int          outstanding,
	output int          mismatches
);

	typedef struct {
		status_t            status;
		logic [3:0]         position;
		logic signed [31:0] head;
		logic               empty;
		logic [4:0]         count;
	} answer_t;

	logic signed [31:0] list_vals [SPQ_DEPTH];
	int unsigned        list_len;
	answer_t            expected_answers [$];
	int                 waiting = 0;
	int                 fail_total = 0;

	assign outstanding = waiting;
	assign mismatches  = fail_total;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (fail_total < 50) begin
			$display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
		end
		fail_total++;
	endtask

	// Applies one request to the local copy of the list and returns the answer
	// that the block must give for it.
	function automatic answer_t apply_request(input logic [1:0] kind,
		input logic signed [31:0] v);
		answer_t     a;
		status_t     st;
		int unsigned pos;
		int unsigned i;
		st  = ST_NOT_FOUND;
		pos = 0;
		if (kind == REQ_INSERT) begin
			if (list_len >= SPQ_DEPTH) begin
				st = ST_FULL;
			end else begin
				pos = list_len;
				for (i = 0; i < list_len; i++) begin
					if (list_vals[i] >= v) begin
						pos = i;
						break;
					end
				end
				for (i = list_len; i > pos; i--) begin
					list_vals[i] = list_vals[i - 1];
				end
				list_vals[pos] = v;
				list_len++;
				st = ST_DONE;
			end
		end else if (kind == REQ_REMOVE || kind == REQ_FIND) begin
			pos = list_len;
			for (i = 0; i < list_len; i++) begin
				if (list_vals[i] == v) begin
					pos = i;
					break;
				end
			end
			if (pos < list_len) begin
				st = ST_DONE;
				if (kind == REQ_REMOVE) begin
					for (i = pos; i + 1 < list_len; i++) begin
						list_vals[i] = list_vals[i + 1];
					end
					list_len--;
				end
			end else begin
				pos = 0;
			end
		end
		a.status   = st;
		a.position = (st == ST_DONE) ? pos[3:0] : 4'd0;
		a.head     = (list_len > 0) ? list_vals[0] : 32'sd0;
		a.empty    = (list_len == 0);
		a.count    = list_len[4:0];
		return a;
	endfunction

	task automatic check_answer();
		answer_t want;
		if (expected_answers.size() == 0) begin
			report_mismatch("result with nothing expected", m_tdata[31:0], 32'd0);
			return;
		end
		want = expected_answers.pop_front();
		if (m_tuser != want.status) report_mismatch("status", m_tuser, want.status);
		if (m_tdata[3:0] != want.position)
			report_mismatch("position", m_tdata[3:0], want.position);
		if (m_tdata[35:4] != want.head) report_mismatch("head_value", m_tdata[35:4], want.head);
		if (m_tdata[36] != want.empty) report_mismatch("is_empty", m_tdata[36], want.empty);
		if (m_tdata[41:37] != want.count)
			report_mismatch("entry_count", m_tdata[41:37], want.count);
	endtask

	// A result leaving at the same edge as a new request always belongs to an
	// older request, so the result is checked before the new answer is queued.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_answers.delete();
			list_len = 0;
			waiting <= 0;
		end else begin
			if (m_tvalid && m_tready) check_answer();
			if (s_tvalid && s_tready)
				expected_answers.push_back(apply_request(s_tuser, s_tdata[31:0]));
			waiting <= expected_answers.size();
		end
	end

endmodule

### verif/tb_top.sv
// Top of the sorted priority queue testbench: clock, reset, request stimulus
// and result back-pressure. Depends on spq_pkg, spq_checker and the block.
`timescale 1ns / 100ps

module tb_top;
	import spq_pkg::*;

	localparam logic [1:0]  REQ_UNUSED   = 2'd3;
	localparam logic [31:0] VAL_MIN      = 32'h8000_0000;
	localparam logic [31:0] VAL_MAX      = 32'h7fff_ffff;
	localparam int          RANDOM_ITEMS = 2000;
	localparam int          HOLD_CYCLES  = 400;
	localparam int          CYCLE_LIMIT  = 600000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // value[31:0]
	logic [1:0]  s_tuser;   // req_type[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // position, head_value, is_empty, entry_count
	logic [1:0]  m_tuser;   // status[1:0]
	int          outstanding;
	int          mismatches;

	int          src_idle_pct  = 26;
	int          sink_idle_pct = 26;
	logic        sink_hold     = 1'b0;
	logic [31:0] recent_vals [16];
	int          recent_wr     = 0;
	int          cycle_count   = 0;

	always #6 clk = ~clk;

	sorted_priority_queue_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	spq_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	// Offers one request and returns at the edge of its transfer, sometimes after
	// a further random gap with tvalid low.
	task automatic send_item(input logic [1:0] rq, input logic [31:0] v);
		s_tvalid <= 1'b1;
		s_tuser  <= rq;
		s_tdata  <= v;
		if (rq == REQ_INSERT) begin
			recent_vals[recent_wr] = v;
			recent_wr = (recent_wr + 1) % 16;
		end
		do @(posedge clk); while (!s_tready);
		if ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Values are drawn mostly from a narrow range and from recent inserts, so
	// that removes and finds often hit and equal values are common.
	function automatic logic [31:0] pick_value();
		int r;
		int narrow;
		r = $urandom_range(99);
		narrow = int'($urandom_range(12)) - 6;
		if (r < 35) return 32'(narrow);
		if (r < 55) return recent_vals[$urandom_range(15)];
		if (r < 65) begin
			case ($urandom_range(3))
				0: return VAL_MIN;
				1: return VAL_MAX;
				2: return 32'hffff_ffff;
				default: return 32'd0;
			endcase
		end
		return $urandom;
	endfunction

	// Phases alternate between filling, draining and a balanced mix so that
	// the list keeps reaching both full and empty.
	function automatic logic [1:0] pick_request(input int phase);
		int r;
		int ins_pct;
		int rem_pct;
		r = $urandom_range(99);
		ins_pct = (phase == 0) ? 65 : (phase == 1) ? 15 : 40;
		rem_pct = (phase == 0) ? 15 : (phase == 1) ? 65 : 35;
		if (r < ins_pct) return REQ_INSERT;
		if (r < ins_pct + rem_pct) return REQ_REMOVE;
		if (r < 99) return REQ_FIND;
		return REQ_UNUSED;
	endfunction

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sink_hold) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				sink_hold = 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int          sent;
		logic [1:0]  rq;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = REQ_INSERT;
		foreach (recent_vals[i]) recent_vals[i] = 32'd0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list: misses, the unused code, then extremes and equal values.
		send_item(REQ_FIND, 32'd0);
		send_item(REQ_REMOVE, 32'd7);
		send_item(REQ_UNUSED, 32'd0);
		send_item(REQ_INSERT, VAL_MAX);
		send_item(REQ_INSERT, VAL_MIN);
		send_item(REQ_INSERT, 32'd0);
		send_item(REQ_INSERT, 32'hffff_ffff);
		send_item(REQ_INSERT, 32'd0);
		send_item(REQ_FIND, 32'd0);
		send_item(REQ_FIND, VAL_MIN);
		// The first zero sits in the middle; only that entry may go.
		send_item(REQ_REMOVE, 32'd0);
		send_item(REQ_UNUSED, VAL_MAX);
		repeat (12) send_item(REQ_INSERT, $urandom);
		send_item(REQ_INSERT, 32'd5);
		send_item(REQ_REMOVE, VAL_MIN);
		send_item(REQ_FIND, VAL_MAX);
		drain_results();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			rq = pick_request((sent / 150) % 3);
			send_item(rq, pick_value());
			if (rq != REQ_UNUSED) begin
				sent++;
				case (sent)
					400: sink_hold = 1'b1;
					800: begin
						src_idle_pct  = 0;
						sink_idle_pct = 0;
					end
					1100: begin
						src_idle_pct  = 26;
						sink_idle_pct = 26;
					end
					1500: drain_results();
					default: ;
				endcase
			end
		end
		drain_results();
		repeat (60) @(posedge clk);

		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
